### rtl/pwli_pkg.sv
package pwli_pkg;

    localparam int MAX_POINTS = 64;

    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_COMMIT = 2'd1;
    localparam logic [1:0] MODE_EVAL   = 2'd2;
    localparam logic [1:0] MODE_READ   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD     = 2'd1;
    localparam logic [1:0] ST_NOT_ASC = 2'd2;

    localparam logic signed [31:0] Y_RESET = 32'sd65536;

    typedef struct packed {
        logic [1:0]         mode;
        logic [5:0]         point_index;
        logic [6:0]         new_count;
        logic signed [31:0] x_in;
        logic signed [31:0] y_in;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] y_out;
        logic signed [31:0] x_out;
        logic [1:0]         status;
        logic [6:0]         count_out;
    } out_item_t;

    // datapath commands from the controller
    typedef enum logic [4:0] {
        OP_NONE   = 5'd0,
        OP_LATCH  = 5'd1,
        OP_WRITE  = 5'd2,
        OP_RDREQ  = 5'd3,
        OP_CHK    = 5'd4,
        OP_SRCH   = 5'd5,
        OP_SEGA   = 5'd6,
        OP_SEGB   = 5'd7,
        OP_MUL    = 5'd8,
        OP_DIV    = 5'd9,
        OP_FIN    = 5'd10,
        OP_RDOUT  = 5'd11,
        OP_CMOUT  = 5'd12,
        OP_FLAT   = 5'd13,
        OP_ONEPT  = 5'd14,
        OP_SIMPLE = 5'd15,
        OP_DIFF   = 5'd16
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       idx_bad;
        logic       cnt_bad;
        logic       cnt_one;
        logic       chk_done;
        logic       srch_done;
        logic       den_zero;
        logic       div_done;
    } dp_stat_t;

endpackage

### rtl/pwli_ctrl.sv
module pwli_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output pwli_pkg::dp_cmd_t cmd,
    input  pwli_pkg::dp_stat_t stat
);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_DEC   = 12'b000000000010,
        S_CHK   = 12'b000000000100,
        S_SRCH  = 12'b000000001000,
        S_SEGA  = 12'b000000010000,
        S_SEGB  = 12'b000000100000,
        S_MUL   = 12'b000001000000,
        S_DIV   = 12'b000010000000,
        S_FIN   = 12'b000100000000,
        S_RDREQ = 12'b001000000000,
        S_RDOUT = 12'b010000000000,
        S_SEGW  = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = pwli_pkg::OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = pwli_pkg::OP_LATCH;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                unique case (stat.mode)
                    pwli_pkg::MODE_LOAD:
                    begin
                        cmd.op     = pwli_pkg::OP_WRITE;
                        state_next = S_IDLE;
                    end
                    pwli_pkg::MODE_COMMIT:
                    begin
                        if (stat.cnt_bad)
                        begin
                            cmd.op     = pwli_pkg::OP_SIMPLE;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd.op     = pwli_pkg::OP_CHK;
                            state_next = S_CHK;
                        end
                    end
                    pwli_pkg::MODE_EVAL:
                    begin
                        if (stat.cnt_one)
                        begin
                            cmd.op     = pwli_pkg::OP_ONEPT;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd.op     = pwli_pkg::OP_SRCH;
                            state_next = S_SRCH;
                        end
                    end
                    default:
                    begin
                        if (stat.idx_bad)
                        begin
                            cmd.op     = pwli_pkg::OP_SIMPLE;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd.op     = pwli_pkg::OP_RDREQ;
                            state_next = S_RDREQ;
                        end
                    end
                endcase
            end
            S_CHK:
            begin
                if (stat.chk_done)
                begin
                    cmd.op     = pwli_pkg::OP_CMOUT;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.op = pwli_pkg::OP_CHK;
                end
            end
            S_SRCH:
            begin
                if (stat.srch_done)
                begin
                    cmd.op     = pwli_pkg::OP_SEGA;
                    state_next = S_SEGA;
                end
                else
                begin
                    cmd.op = pwli_pkg::OP_SRCH;
                end
            end
            S_SEGA:
            begin
                cmd.op     = pwli_pkg::OP_SEGB;
                state_next = S_SEGB;
            end
            S_SEGB:
            begin
                cmd.op     = pwli_pkg::OP_DIFF;
                state_next = S_SEGW;
            end
            S_SEGW:
            begin
                if (stat.den_zero)
                begin
                    cmd.op     = pwli_pkg::OP_FLAT;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.op     = pwli_pkg::OP_MUL;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.op     = pwli_pkg::OP_DIV;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.op = pwli_pkg::OP_DIV;
                end
            end
            S_FIN:
            begin
                cmd.op     = pwli_pkg::OP_FIN;
                state_next = S_IDLE;
            end
            S_RDREQ:
            begin
                cmd.op     = pwli_pkg::OP_RDREQ;
                state_next = S_RDOUT;
            end
            S_RDOUT:
            begin
                cmd.op     = pwli_pkg::OP_RDOUT;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/pwli_dp.sv
module pwli_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pwli_pkg::in_item_t   item,
    input  pwli_pkg::dp_cmd_t    cmd,
    output pwli_pkg::dp_stat_t   stat,
    output logic                 done,
    output pwli_pkg::out_item_t  result
);

    localparam int AW = $clog2(pwli_pkg::MAX_POINTS);
    localparam int CW = 7;

    logic signed [31:0] mem_x [pwli_pkg::MAX_POINTS];
    logic signed [31:0] mem_y [pwli_pkg::MAX_POINTS];

    pwli_pkg::in_item_t it_reg;
    logic [CW-1:0]      count_reg;
    logic               zero_wr_reg;
    logic signed [31:0] y_first_reg;

    // one read port at a single address; the data and the address are registered
    logic [AW-1:0]      ra, ra_reg;
    logic signed [31:0] rx_reg, ry_reg;
    logic               rd_zero;

    logic [CW-1:0]      lo_reg, hi_reg, ci_reg;
    logic [1:0]         ph_reg;
    logic               chk_bad_reg;
    logic signed [31:0] x0_reg, y0_reg;
    logic signed [32:0] den_reg, dy_reg, dx_reg;
    logic [65:0]        prod_reg;
    logic [32:0]        dm_reg;
    logic [66:0]        rem_reg;
    logic [6:0]         dcnt_reg;
    logic               neg_reg;

    logic [AW:0] k;
    assign k = ((AW+1)'(lo_reg) + (AW+1)'(hi_reg)) >> 1;

    // table entry 0 holds its reset point until first write
    always_ff @(posedge clk)
    begin
        if (cmd.op == pwli_pkg::OP_WRITE &&
            (AW+1)'(it_reg.point_index) < (AW+1)'(pwli_pkg::MAX_POINTS))
        begin
            mem_x[it_reg.point_index[AW-1:0]] <= it_reg.x_in;
            mem_y[it_reg.point_index[AW-1:0]] <= it_reg.y_in;
        end
        rx_reg <= mem_x[ra];
        ry_reg <= mem_y[ra];
        ra_reg <= ra;
    end

    assign rd_zero = (ra_reg == '0) && !zero_wr_reg;

    logic signed [31:0] rx, ry;
    assign rx = rd_zero ? 32'sd0 : rx_reg;
    assign ry = rd_zero ? pwli_pkg::Y_RESET : ry_reg;

    always_comb
    begin
        ra = '0;
        priority case (1'b1)
            (cmd.op == pwli_pkg::OP_RDREQ): ra = it_reg.point_index[AW-1:0];
            (cmd.op == pwli_pkg::OP_CHK):   ra = ci_reg[AW-1:0];
            (cmd.op == pwli_pkg::OP_SRCH):
            begin
                if (ph_reg == 2'd0)      ra = AW'(1);
                else if (ph_reg == 2'd1) ra = AW'(count_reg - 7'd1);
                else                     ra = k[AW-1:0];
            end
            (cmd.op == pwli_pkg::OP_SEGA):  ra = AW'(hi_reg - 7'd1);
            (cmd.op == pwli_pkg::OP_SEGB):  ra = hi_reg[AW-1:0];
            default:                        ra = '0;
        endcase
    end

    logic signed [31:0] prev_x_reg;
    logic               eq_le, eq_ge;
    assign eq_le = it_reg.x_in <= rx;
    assign eq_ge = it_reg.x_in >= rx;

    // search phases: 0 issue x1, 1 check x1 issue last, 2 check last, 3 bisect
    logic [CW-1:0] kq_reg;
    logic          pend_reg;

    assign stat.mode      = it_reg.mode;
    assign stat.idx_bad   = ({1'b0, it_reg.point_index} >= count_reg);
    assign stat.cnt_bad   = (it_reg.new_count == 7'd0) ||
                            (32'(it_reg.new_count) > pwli_pkg::MAX_POINTS);
    assign stat.cnt_one   = (count_reg <= 7'd1);
    assign stat.chk_done  = (ph_reg == 2'd1) && (ci_reg > count_reg || chk_bad_reg);
    assign stat.srch_done = (ph_reg == 2'd3) && !pend_reg && !(hi_reg > lo_reg + 7'd1);
    assign stat.den_zero  = (den_reg == '0);
    assign stat.div_done  = (dcnt_reg == 7'd0);

    logic [32:0] dxm, dym, denm;
    assign dxm = dx_reg[32] ? 33'(-dx_reg) : 33'(dx_reg);
    assign dym = dy_reg[32] ? 33'(-dy_reg) : 33'(dy_reg);
    assign denm = den_reg[32] ? 33'(-den_reg) : 33'(den_reg);

    logic [67:0] trial;
    assign trial = {rem_reg, prod_reg[65]} - {35'd0, dm_reg};

    // a quotient of 2^33 or more saturates whatever y0 is
    logic signed [34:0] sum;
    logic [32:0]        qlo;
    logic               q_big;
    assign qlo   = prod_reg[32:0];
    assign q_big = |prod_reg[65:33];
    assign sum = neg_reg ? {{3{y0_reg[31]}}, y0_reg} - {2'b00, qlo}
                         : {{3{y0_reg[31]}}, y0_reg} + {2'b00, qlo};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= 7'd1;
            zero_wr_reg <= 1'b0;
            y_first_reg <= pwli_pkg::Y_RESET;
            done        <= 1'b0;
        end
        else
        begin
            done <= (cmd.op == pwli_pkg::OP_WRITE) ||
                    (cmd.op == pwli_pkg::OP_SIMPLE) || (cmd.op == pwli_pkg::OP_CMOUT) ||
                    (cmd.op == pwli_pkg::OP_RDOUT) || (cmd.op == pwli_pkg::OP_FLAT) ||
                    (cmd.op == pwli_pkg::OP_ONEPT) || (cmd.op == pwli_pkg::OP_FIN);
            if (cmd.op == pwli_pkg::OP_WRITE && it_reg.point_index == '0)
            begin
                zero_wr_reg <= 1'b1;
                y_first_reg <= it_reg.y_in;
            end
            if (cmd.op == pwli_pkg::OP_CHK && ph_reg == 2'd0)
            begin
                count_reg <= it_reg.new_count;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            pwli_pkg::OP_LATCH:
            begin
                it_reg <= item;
                ph_reg <= 2'd0;
            end
            pwli_pkg::OP_WRITE:
            begin
                result.y_out     <= '0;
                result.x_out     <= '0;
                result.status    <= (32'(it_reg.point_index) < pwli_pkg::MAX_POINTS) ?
                                    pwli_pkg::ST_OK : pwli_pkg::ST_BAD;
                result.count_out <= count_reg;
            end
            pwli_pkg::OP_CHK:
            begin
                // ci walks 0..count (stopping early on a bad pair), reading one entry per cycle
                if (ph_reg == 2'd0)
                begin
                    ci_reg      <= 7'd0;
                    ph_reg      <= 2'd1;
                    chk_bad_reg <= 1'b0;
                    pend_reg    <= 1'b0;
                end
                else
                begin
                    ci_reg   <= ci_reg + 7'd1;
                    pend_reg <= 1'b1;
                    kq_reg   <= ci_reg;
                    if (pend_reg)
                    begin
                        if (kq_reg != 7'd0 && rx <= prev_x_reg) chk_bad_reg <= 1'b1;
                        prev_x_reg <= rx;
                    end
                end
            end
            pwli_pkg::OP_CMOUT:
            begin
                result.y_out     <= '0;
                result.x_out     <= '0;
                result.status    <= chk_bad_reg ? pwli_pkg::ST_NOT_ASC : pwli_pkg::ST_OK;
                result.count_out <= count_reg;
            end
            pwli_pkg::OP_SRCH:
            begin
                if (ph_reg == 2'd0)
                begin
                    hi_reg   <= count_reg - 7'd1;
                    lo_reg   <= 7'd1;
                    ph_reg   <= 2'd1;
                    pend_reg <= 1'b0;
                end
                else if (ph_reg == 2'd1)
                begin
                    if (eq_le) hi_reg <= 7'd1;
                    ph_reg <= 2'd2;
                end
                else if (ph_reg == 2'd2)
                begin
                    if (eq_ge) lo_reg <= count_reg - 7'd1;
                    ph_reg <= 2'd3;
                end
                else
                begin
                    if (!pend_reg)
                    begin
                        pend_reg <= (hi_reg > lo_reg + 7'd1);
                        kq_reg   <= 7'(k);
                    end
                    else
                    begin
                        if (eq_le) hi_reg <= kq_reg;
                        if (eq_ge) lo_reg <= kq_reg;
                        pend_reg <= 1'b0;
                    end
                end
            end
            pwli_pkg::OP_SEGB:
            begin
                x0_reg <= rx;
                y0_reg <= ry;
            end
            pwli_pkg::OP_DIFF:
            begin
                den_reg <= {rx[31], rx} - {x0_reg[31], x0_reg};
                dx_reg  <= {it_reg.x_in[31], it_reg.x_in} - {x0_reg[31], x0_reg};
                dy_reg  <= {ry[31], ry} - {y0_reg[31], y0_reg};
            end
            pwli_pkg::OP_MUL:
            begin
                prod_reg <= 66'(dxm) * 66'(dym);
                dm_reg   <= denm;
                neg_reg  <= (dx_reg[32] != dy_reg[32]) != den_reg[32];
                dcnt_reg <= 7'd66;
                rem_reg  <= '0;
            end
            pwli_pkg::OP_DIV:
            begin
                // restoring division, one quotient bit per cycle; quotient shifts into prod
                if (trial[67] == 1'b0)
                begin
                    rem_reg  <= trial[66:0];
                    prod_reg <= {prod_reg[64:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= {rem_reg[65:0], prod_reg[65]};
                    prod_reg <= {prod_reg[64:0], 1'b0};
                end
                dcnt_reg <= dcnt_reg - 7'd1;
            end
            pwli_pkg::OP_FIN:
            begin
                result.x_out     <= '0;
                result.status    <= pwli_pkg::ST_OK;
                result.count_out <= count_reg;
                if (q_big)                       result.y_out <= neg_reg ? 32'h80000000
                                                                         : 32'h7fffffff;
                else if (sum > 35'sd2147483647)  result.y_out <= 32'h7fffffff;
                else if (sum < -35'sd2147483648) result.y_out <= 32'h80000000;
                else                             result.y_out <= sum[31:0];
            end
            pwli_pkg::OP_FLAT:
            begin
                result.y_out     <= y0_reg;
                result.x_out     <= '0;
                result.status    <= pwli_pkg::ST_NOT_ASC;
                result.count_out <= count_reg;
            end
            pwli_pkg::OP_ONEPT:
            begin
                result.y_out     <= y_first_reg;
                result.x_out     <= '0;
                result.status    <= pwli_pkg::ST_OK;
                result.count_out <= count_reg;
            end
            pwli_pkg::OP_RDREQ:
            begin
                result.y_out     <= '0;
                result.x_out     <= '0;
                result.status    <= pwli_pkg::ST_OK;
                result.count_out <= count_reg;
            end
            pwli_pkg::OP_RDOUT:
            begin
                result.y_out  <= ry;
                result.x_out  <= rx;
                result.status <= pwli_pkg::ST_OK;
            end
            pwli_pkg::OP_SIMPLE:
            begin
                result.y_out     <= '0;
                result.x_out     <= '0;
                result.status    <= pwli_pkg::ST_BAD;
                result.count_out <= count_reg;
            end
            default:
            begin
            end
        endcase
    end

endmodule

### rtl/piecewise_linear_table_interp_unit.sv
// commit checks the new count of points; evaluate bisects the table and then runs the
// bit-serial 66-bit divider; a bad count or index ends at decode, a one-point evaluate skips the search
// throughput: one item at a time; start is taken only while busy is low
// result shows for one cycle with done; the receiver cannot stall
// reset (async, active low): count 1, point 0 = (0, 1.0), controller idle
module piecewise_linear_table_interp_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  pwli_pkg::in_item_t   item,
    output logic                 busy,
    output logic                 done,
    output pwli_pkg::out_item_t  result
);

    pwli_pkg::dp_cmd_t  cmd;
    pwli_pkg::dp_stat_t stat;

    pwli_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    pwli_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .done   (done),
        .result (result)
    );

endmodule

### rtl/pwli_checker.sv
module pwli_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input pwli_pkg::out_item_t result
);

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("start not taken");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.count_out != 7'd0)) else $error("count zero");

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status != 2'd3)) else $error("bad status");

endmodule

bind piecewise_linear_table_interp_unit pwli_checker u_pwli_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

### dv/piecewise_linear_table_interp_unit_tb.sv
module piecewise_linear_table_interp_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPTS = pwli_pkg::MAX_POINTS;

    class pwl_curve_model;
        int                  tbl_x [NPTS];
        int                  tbl_y [NPTS];
        int unsigned         npts_used;
        int                  errors;
        pwli_pkg::out_item_t pending_results [$];

        function new();
            tbl_x[0] = 0;
            tbl_y[0] = pwli_pkg::Y_RESET;
            npts_used = 1;
            errors = 0;
        endfunction

        function void interp(input longint xq, output int y, output logic [1:0] st);
            int unsigned hi, lo, k;
            longint x0, y0, den, dx, dy, s;
            bit [127:0] mdx, mdy, mden, quot;
            bit neg;
            st = pwli_pkg::ST_OK;
            if (npts_used <= 1) begin
                y = tbl_y[0];
                return;
            end
            hi = npts_used - 1;
            lo = 1;
            if (xq <= longint'(tbl_x[1])) hi = 1;
            if (xq >= longint'(tbl_x[npts_used - 1])) lo = npts_used - 1;
            while (hi > lo + 1) begin
                k = (hi + lo) / 2;
                if (xq <= longint'(tbl_x[k])) hi = k;
                if (xq >= longint'(tbl_x[k])) lo = k;
            end
            x0 = tbl_x[hi - 1];
            y0 = tbl_y[hi - 1];
            den = longint'(tbl_x[hi]) - x0;
            if (den == 0) begin
                y = int'(y0);
                st = pwli_pkg::ST_NOT_ASC;
                return;
            end
            dx = xq - x0;
            dy = longint'(tbl_y[hi]) - y0;
            mdx = (dx < 0) ? -dx : dx;
            mdy = (dy < 0) ? -dy : dy;
            mden = (den < 0) ? -den : den;
            quot = (mdx * mdy) / mden;
            neg = ((dx < 0) != (dy < 0)) != (den < 0);
            if (quot > 128'h2_0000_0000) begin
                y = neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
                return;
            end
            s = neg ? y0 - longint'(quot[63:0]) : y0 + longint'(quot[63:0]);
            if (s > 64'sd2147483647) y = 32'sh7fff_ffff;
            else if (s < -64'sd2147483648) y = 32'sh8000_0000;
            else y = int'(s);
        endfunction

        function void note_item(pwli_pkg::in_item_t it);
            pwli_pkg::out_item_t r;
            int yv;
            logic [1:0] st;
            r = '0;
            r.status = pwli_pkg::ST_OK;
            case (it.mode)
                pwli_pkg::MODE_LOAD: begin
                    tbl_x[it.point_index] = it.x_in;
                    tbl_y[it.point_index] = it.y_in;
                end
                pwli_pkg::MODE_COMMIT: begin
                    if (it.new_count == 0 || it.new_count > NPTS) begin
                        r.status = pwli_pkg::ST_BAD;
                    end
                    else begin
                        npts_used = it.new_count;
                        for (int i = 1; i < npts_used; i++)
                            if (tbl_x[i] <= tbl_x[i - 1]) r.status = pwli_pkg::ST_NOT_ASC;
                    end
                end
                pwli_pkg::MODE_EVAL: begin
                    interp(longint'(it.x_in), yv, st);
                    r.y_out = yv;
                    r.status = st;
                end
                default: begin
                    if (it.point_index < npts_used) begin
                        r.x_out = tbl_x[it.point_index];
                        r.y_out = tbl_y[it.point_index];
                    end
                    else begin
                        r.status = pwli_pkg::ST_BAD;
                    end
                end
            endcase
            r.count_out = npts_used[6:0];
            pending_results.push_back(r);
        endfunction

        function void check_result(pwli_pkg::out_item_t got);
            pwli_pkg::out_item_t exp_r;
            if (pending_results.size() == 0) begin
                $error("result with nothing pending: %p", got);
                errors++;
                return;
            end
            exp_r = pending_results.pop_front();
            if (got.y_out !== exp_r.y_out) begin
                $error("y_out exp %0d got %0d", exp_r.y_out, got.y_out);
                errors++;
            end
            if (got.x_out !== exp_r.x_out) begin
                $error("x_out exp %0d got %0d", exp_r.x_out, got.x_out);
                errors++;
            end
            if (got.status !== exp_r.status) begin
                $error("status exp %0d got %0d", exp_r.status, got.status);
                errors++;
            end
            if (got.count_out !== exp_r.count_out) begin
                $error("count_out exp %0d got %0d", exp_r.count_out, got.count_out);
                errors++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                start;
    pwli_pkg::in_item_t  item;
    logic                busy;
    logic                done;
    pwli_pkg::out_item_t result;

    pwl_curve_model curve;
    bit             loaded [NPTS];
    int             items_sent;
    int             idle_pct;

    piecewise_linear_table_interp_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done) curve.check_result(result);
    end

    function automatic pwli_pkg::in_item_t rand_item();
        pwli_pkg::in_item_t it;
        it.mode = 2'($urandom_range(0, 3));
        it.point_index = 6'($urandom_range(0, 63));
        it.new_count = 7'($urandom_range(0, 127));
        it.x_in = $urandom;
        it.y_in = $urandom;
        return it;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(pwli_pkg::in_item_t it);
        int nc;
        if (it.mode == pwli_pkg::MODE_COMMIT && it.new_count >= 1 && it.new_count <= NPTS) begin
            // never commit over slots that were never loaded
            nc = 0;
            while (nc < it.new_count && loaded[nc]) nc++;
            it.new_count = 7'(nc);
        end
        if ($urandom_range(0, 99) < idle_pct) begin
            start = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        start = 1'b1;
        item = it;
        do @(posedge clk); while (busy);
        curve.note_item(it);
        if (it.mode == pwli_pkg::MODE_LOAD) loaded[it.point_index] = 1'b1;
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_op(logic [1:0] mode, int idx, int nc, int xv, int yv);
        pwli_pkg::in_item_t it;
        it = rand_item();
        it.mode = mode;
        it.point_index = 6'(idx);
        it.new_count = 7'(nc);
        it.x_in = xv;
        it.y_in = yv;
        send_item(it);
    endtask

    // ascending table, commit, then evaluations and reads on it
    task automatic curve_session();
        int n, sel;
        longint xs [NPTS];
        longint span, lowv, highv, rng, xq;
        pwli_pkg::in_item_t it;
        sel = $urandom_range(0, 99);
        if (sel < 10) n = 1;
        else if (sel < 80) n = $urandom_range(2, 8);
        else if (sel < 95) n = $urandom_range(9, 63);
        else n = NPTS;
        if ($urandom_range(0, 3) == 0) begin
            span = 64'd4294967296 / n;
            for (int i = 0; i < n; i++)
                xs[i] = -64'sd2147483648 + i * span + longint'($urandom) % span;
        end
        else begin
            xs[0] = longint'($urandom_range(0, 2097152)) - 1048576;
            for (int i = 1; i < n; i++) xs[i] = xs[i - 1] + $urandom_range(1, 262144);
        end
        for (int i = 0; i < n; i++)
            send_op(pwli_pkg::MODE_LOAD, i, 0, int'(xs[i]),
                    ($urandom_range(0, 1) != 0) ? int'($urandom)
                                                : int'($urandom_range(0, 1 << 20)) - (1 << 19));
        send_op(pwli_pkg::MODE_COMMIT, 0, n, 0, 0);
        lowv = xs[0];
        highv = xs[n - 1];
        rng = highv - lowv + 1;
        repeat ($urandom_range(3, 8)) begin
            it = rand_item();
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
                it.mode = pwli_pkg::MODE_EVAL;
                if (sel < 20) xq = xs[$urandom_range(0, n - 1)];
                else if (sel < 55)
                    xq = lowv - rng / 4 + longint'({$urandom, $urandom} % (rng * 3 / 2 + 1));
                else xq = longint'(int'($urandom));
                if (xq > 64'sd2147483647) xq = 64'sd2147483647;
                if (xq < -64'sd2147483648) xq = -64'sd2147483648;
                it.x_in = int'(xq);
            end
            else begin
                it.mode = pwli_pkg::MODE_READ;
                it.point_index = ($urandom_range(0, 3) != 0) ? 6'($urandom_range(0, n - 1))
                                                           : 6'($urandom_range(0, 63));
            end
            send_item(it);
        end
    endtask

    initial
    begin
        curve = new();
        loaded[0] = 1'b1;
        items_sent = 0;
        idle_pct = 7;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset table, bad counts and indexes
        send_op(pwli_pkg::MODE_EVAL, 0, 0, 32'sh7fff_ffff, 0);
        send_op(pwli_pkg::MODE_READ, 0, 0, 0, 0);
        send_op(pwli_pkg::MODE_READ, 1, 0, 0, 0);
        send_op(pwli_pkg::MODE_COMMIT, 0, 0, 0, 0);
        send_op(pwli_pkg::MODE_COMMIT, 0, 65, 0, 0);
        send_op(pwli_pkg::MODE_COMMIT, 0, 127, 0, 0);
        // steep segment: saturation both ways and extremes of x
        send_op(pwli_pkg::MODE_LOAD, 0, 0, 0, 0);
        send_op(pwli_pkg::MODE_LOAD, 1, 0, 1, 32'sh7fff_ffff);
        send_op(pwli_pkg::MODE_COMMIT, 0, 2, 0, 0);
        send_op(pwli_pkg::MODE_EVAL, 0, 0, 32'sh7fff_ffff, 0);
        send_op(pwli_pkg::MODE_EVAL, 0, 0, 32'sh8000_0000, 0);
        send_op(pwli_pkg::MODE_LOAD, 1, 0, 32'sh7fff_ffff, 32'sh8000_0000);
        send_op(pwli_pkg::MODE_LOAD, 0, 0, 32'sh8000_0000, 32'sh7fff_ffff);
        send_op(pwli_pkg::MODE_EVAL, 0, 0, 0, 0);
        send_op(pwli_pkg::MODE_READ, 1, 0, 0, 0);
        send_op(pwli_pkg::MODE_READ, 63, 0, 0, 0);
        // equal x values: not ascending, flat segment
        send_op(pwli_pkg::MODE_LOAD, 1, 0, 32'sh8000_0000, 5);
        send_op(pwli_pkg::MODE_COMMIT, 0, 2, 0, 0);
        send_op(pwli_pkg::MODE_EVAL, 0, 0, 12345, 0);
        send_op(pwli_pkg::MODE_LOAD, 63, 0, 32'sh0001_0000, 32'sh0002_0000);

        while (items_sent < 600) begin
            if (items_sent >= 400) idle_pct = 0;
            else if (items_sent >= 200) idle_pct = 65;
            if ($urandom_range(0, 99) < 70) curve_session();
            else send_item(rand_item());
        end
        start = 1'b0;

        while (curve.pending_results.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (curve.errors == 0 && curve.pending_results.size() == 0)
            $display("[piecewise_linear_table_interp_unit] OK");
        else
            $display("[piecewise_linear_table_interp_unit] ERROR");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("[piecewise_linear_table_interp_unit] ERROR");
        $finish;
    end
endmodule

### files.f
rtl/pwli_pkg.sv
rtl/pwli_ctrl.sv
rtl/pwli_dp.sv
rtl/piecewise_linear_table_interp_unit.sv
rtl/pwli_checker.sv
dv/piecewise_linear_table_interp_unit_tb.sv
